// ----- sv/snf_pkg.sv -----
// Shared types, fixed-point constants and the permutation table of the
// fractal simplex noise pipeline. No dependencies.
package snf_pkg;

    // Accumulator and corner offset widths (sized for up to 16 octaves)
    localparam int TOT_W = 53;
    localparam int DEN_W = 29;
    localparam int XW    = 40;
    localparam int CW    = TOT_W + 1;
    localparam int QW    = 17;

    // Skew, unskew and output scale factors, falloff and corner offset constants
    localparam logic signed [32:0]   SKEW_Q32   = 33'sd1572067135;
    localparam logic signed [31:0]   UNSKEW_Q32 = 32'sd907633384;
    localparam logic signed [23:0]   SCALE_Q16  = 24'sd2964236;
    localparam logic signed [36:0]   HALF_Q32   = 37'sd2147483648;
    localparam logic signed [XW-1:0] ONE_Q16    = 40'sd65536;
    localparam logic signed [XW-1:0] G2_Q16     = 40'sd13849;
    localparam logic signed [XW-1:0] G2X2_Q16   = 40'sd27699;
    localparam logic signed [XW-1:0] FAR_Q16    = 40'sd131072;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // Per-item state handed from octave to octave
    typedef struct packed {
        logic signed [31:0]      x;
        logic signed [31:0]      y;
        logic [31:0]             freq;
        logic [23:0]             amp;
        logic signed [TOT_W-1:0] total;
        logic [DEN_W-1:0]        denom;
    } t_acc;

    // One stage of the normalizing divider
    typedef struct packed {
        logic [CW-1:0]  rem;
        logic [QW-1:0]  quo;
        logic [DEN_W:0] dvs;
        logic           neg;
        logic           zero;
    } t_div;

endpackage

// ----- sv/snf_octave.sv -----
// One octave of 2D simplex noise as a 15-stage pipeline, weighted and
// accumulated into the running sums. Depends on snf_pkg.
module snf_octave (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic         i_active,
    input  logic [15:0]  i_lacunarity,
    input  logic [15:0]  i_persistence,
    input  snf_pkg::t_acc i_acc,
    output logic         o_valid,
    output snf_pkg::t_acc o_acc
);
    import snf_pkg::*;

    localparam int DEPTH = 15;

    logic [DEPTH-1:0] r_v;
    t_acc             r_c [DEPTH-1];
    t_acc             r_out;
    t_acc             n_out;

    // Stage 1: scale point, step frequency
    logic signed [64:0] n1_prod_x, n1_prod_y;
    logic [47:0]        n1_fl;
    t_acc               n1_c;
    logic signed [31:0] r1_px, r1_py;

    assign n1_prod_x = i_acc.x * $signed({1'b0, i_acc.freq});
    assign n1_prod_y = i_acc.y * $signed({1'b0, i_acc.freq});
    assign n1_fl     = i_acc.freq * i_lacunarity;

    always_comb begin
        n1_c      = i_acc;
        n1_c.freq = (|n1_fl[47:40]) ? 32'hFFFF_FFFF : n1_fl[39:8];
    end

    // Stage 2: skew product
    logic signed [32:0] n2_sum;
    logic signed [65:0] n2_sk;
    logic signed [65:0] r2_sk;
    logic signed [31:0] r2_px, r2_py;

    assign n2_sum = 33'(r1_px) + 33'(r1_py);
    assign n2_sk  = n2_sum * SKEW_Q32;

    // Stage 3: cell indices
    logic signed [33:0] n3_s;
    logic signed [34:0] n3_ax, n3_ay;
    logic signed [18:0] r3_i, r3_j;
    logic signed [31:0] r3_px, r3_py;

    assign n3_s  = r2_sk[65:32];
    assign n3_ax = 35'(r2_px) + 35'(n3_s);
    assign n3_ay = 35'(r2_py) + 35'(n3_s);

    // Stage 4: unskew product, first hash lookups
    logic signed [19:0] n4_ij;
    logic signed [51:0] n4_tp;
    logic signed [51:0] r4_tp;
    logic signed [18:0] r4_i, r4_j;
    logic signed [31:0] r4_px, r4_py;
    logic [7:0]         r4_pj0, r4_pj1, r4_ci;

    assign n4_ij = 20'(r3_i) + 20'(r3_j);
    assign n4_tp = n4_ij * UNSKEW_Q32;

    // Stage 5: first corner offset
    logic signed [35:0]   n5_t;
    logic signed [XW-1:0] r5_x0, r5_y0;
    logic [7:0]           r5_pj0, r5_pj1, r5_ci;

    assign n5_t = r4_tp[51:16];

    // Stage 6: triangle pick, other corners, corner hashes
    logic                 n6_i1;
    logic signed [XW-1:0] n6_cx [3];
    logic signed [XW-1:0] n6_cy [3];
    logic [7:0]           n6_h  [3];
    logic signed [XW-1:0] r6_cx [3];
    logic signed [XW-1:0] r6_cy [3];
    logic [5:0]           r6_h  [3];

    always_comb begin
        n6_i1    = r5_x0 > r5_y0;
        n6_cx[0] = r5_x0;
        n6_cy[0] = r5_y0;
        n6_cx[1] = r5_x0 - (n6_i1 ? ONE_Q16 : '0) + G2_Q16;
        n6_cy[1] = r5_y0 - (n6_i1 ? '0 : ONE_Q16) + G2_Q16;
        n6_cx[2] = r5_x0 - ONE_Q16 + G2X2_Q16;
        n6_cy[2] = r5_y0 - ONE_Q16 + G2X2_Q16;
        n6_h[0]  = PERM_ROM[r5_ci + r5_pj0];
        n6_h[1]  = PERM_ROM[r5_ci + {7'd0, n6_i1} + (n6_i1 ? r5_pj0 : r5_pj1)];
        n6_h[2]  = PERM_ROM[r5_ci + 8'd1 + r5_pj1];
    end

    // Stages 7 to 11: per corner falloff and gradient
    logic                 n7_far [3];
    logic signed [17:0]   n7_xs  [3];
    logic signed [17:0]   n7_ys  [3];
    logic                 r7_far [3];
    logic signed [17:0]   r7_xs  [3];
    logic signed [17:0]   r7_ys  [3];
    logic signed [35:0]   r7_sqx [3];
    logic signed [35:0]   r7_sqy [3];
    logic [5:0]           r7_h   [3];

    logic signed [36:0]   n8_tt  [3];
    logic signed [19:0]   n8_u   [3];
    logic signed [19:0]   n8_v   [3];
    logic [31:0]          r8_t   [3];
    logic signed [19:0]   r8_g   [3];

    logic [63:0]          n9_p   [3];
    logic [30:0]          r9_t2  [3];
    logic signed [19:0]   r9_g   [3];

    logic [61:0]          n10_p  [3];
    logic [28:0]          r10_t4 [3];
    logic signed [19:0]   r10_g  [3];

    logic signed [49:0]   r11_c  [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n7_far[l] = (r6_cx[l] >= FAR_Q16) || (r6_cx[l] <= -FAR_Q16) ||
                        (r6_cy[l] >= FAR_Q16) || (r6_cy[l] <= -FAR_Q16);
            n7_xs[l]  = r6_cx[l][17:0];
            n7_ys[l]  = r6_cy[l][17:0];
            n8_tt[l]  = HALF_Q32 - 37'(r7_sqx[l]) - 37'(r7_sqy[l]);
            // Swap axes for all but the low hash codes
            n8_u[l]   = (r7_h[l][5:2] == 4'd0) ? 20'(r7_xs[l]) : 20'(r7_ys[l]);
            n8_v[l]   = (r7_h[l][5:2] == 4'd0) ? 20'(r7_ys[l]) : 20'(r7_xs[l]);
            n8_v[l]   = n8_v[l] <<< 1;
            n9_p[l]   = r8_t[l] * r8_t[l];
            n10_p[l]  = r9_t2[l] * r9_t2[l];
        end
    end

    // Stage 12 and 13: corner sum and scale
    logic signed [51:0] n12_n;
    logic signed [35:0] r12_nf;
    logic signed [59:0] r13_sc;

    assign n12_n = 52'(r11_c[0]) + 52'(r11_c[1]) + 52'(r11_c[2]);

    // Stage 14: weight by amplitude, step amplitude
    logic signed [23:0] n14_val;
    logic signed [48:0] n14_prod;
    logic [39:0]        n14_ap;
    logic signed [47:0] r14_prod;
    logic [23:0]        r14_ampn;

    assign n14_val  = r13_sc[55:32];
    assign n14_prod = $signed({1'b0, r_c[DEPTH-3].amp}) * n14_val;
    assign n14_ap   = r_c[DEPTH-3].amp * i_persistence;

    // Accumulate only for octaves within the configured count
    always_comb begin
        n_out       = r_c[DEPTH-2];
        n_out.amp   = r14_ampn;
        n_out.total = r_c[DEPTH-2].total + (i_active ? TOT_W'(r14_prod) : '0);
        n_out.denom = r_c[DEPTH-2].denom +
                      (i_active ? DEN_W'(r_c[DEPTH-2].amp) : '0);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DEPTH-2:0], i_valid};
        end
    end

    // Advance datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0] <= n1_c;
            for (int k = 1; k < DEPTH - 1; k++) begin
                r_c[k] <= r_c[k-1];
            end
            r1_px  <= n1_prod_x[47:16];
            r1_py  <= n1_prod_y[47:16];
            r2_sk  <= n2_sk;
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r3_i   <= n3_ax[34:16];
            r3_j   <= n3_ay[34:16];
            r3_px  <= r2_px;
            r3_py  <= r2_py;
            r4_tp  <= n4_tp;
            r4_i   <= r3_i;
            r4_j   <= r3_j;
            r4_px  <= r3_px;
            r4_py  <= r3_py;
            r4_ci  <= r3_i[7:0];
            r4_pj0 <= PERM_ROM[r3_j[7:0]];
            r4_pj1 <= PERM_ROM[r3_j[7:0] + 8'd1];
            r5_x0  <= XW'(r4_px) - (XW'(r4_i) <<< 16) + XW'(n5_t);
            r5_y0  <= XW'(r4_py) - (XW'(r4_j) <<< 16) + XW'(n5_t);
            r5_ci  <= r4_ci;
            r5_pj0 <= r4_pj0;
            r5_pj1 <= r4_pj1;
            for (int l = 0; l < 3; l++) begin
                r6_cx[l]  <= n6_cx[l];
                r6_cy[l]  <= n6_cy[l];
                r6_h[l]   <= n6_h[l][5:0];
                r7_far[l] <= n7_far[l];
                r7_xs[l]  <= n7_xs[l];
                r7_ys[l]  <= n7_ys[l];
                r7_sqx[l] <= n7_xs[l] * n7_xs[l];
                r7_sqy[l] <= n7_ys[l] * n7_ys[l];
                r7_h[l]   <= r6_h[l];
                r8_t[l]   <= (r7_far[l] || n8_tt[l][36]) ? 32'd0 : n8_tt[l][31:0];
                r8_g[l]   <= (r7_h[l][0] ? -n8_u[l] : n8_u[l]) +
                             (r7_h[l][1] ? -n8_v[l] : n8_v[l]);
                r9_t2[l]  <= n9_p[l][62:32];
                r9_g[l]   <= r8_g[l];
                r10_t4[l] <= n10_p[l][60:32];
                r10_g[l]  <= r9_g[l];
                r11_c[l]  <= $signed({1'b0, r10_t4[l]}) * r10_g[l];
            end
            r12_nf   <= n12_n[51:16];
            r13_sc   <= r12_nf * SCALE_Q16;
            r14_prod <= n14_prod[47:0];
            r14_ampn <= n14_ap[39:16];
            r_out    <= n_out;
        end
    end

    assign o_valid = r_v[DEPTH-1];
    assign o_acc   = r_out;

    // An octave beyond the count leaves the weighted sum untouched
    a_inactive_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_v[DEPTH-2] && !i_active) |=>
            (o_acc.total == $past(r_c[DEPTH-2].total)))
        else $error("inactive octave changed the weighted sum");

endmodule

// ----- sv/snf_div.sv -----
// Pipelined restoring divider that normalizes the weighted sum by twice the
// amplitude sum, with saturation to Q1.15. Depends on snf_pkg.
module snf_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [snf_pkg::TOT_W-1:0]   i_total,
    input  logic [snf_pkg::DEN_W-1:0]          i_denom,
    output logic                               o_valid,
    output logic signed [15:0]                 o_value
);
    import snf_pkg::*;

    localparam logic signed [15:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [15:0] SAT_NEG = 16'sh8000;
    localparam logic [QW-1:0]      Q_POS   = 17'd32767;
    localparam logic [QW-1:0]      Q_NEG   = 17'd32768;

    logic [QW+1:0]      r_v;
    t_div               r_st [QW+1];
    t_div               n_st [QW+1];
    logic signed [15:0] r_value;
    logic signed [15:0] n_value;
    logic signed [CW-1:0] n_tot;
    logic [CW-1:0]      n_trial;

    // Split sign and magnitude, then one quotient bit per stage
    always_comb begin
        n_tot         = CW'(i_total);
        n_st[0].neg   = i_total < 0;
        n_st[0].rem   = n_st[0].neg ? -n_tot : n_tot;
        n_st[0].dvs   = {i_denom, 1'b0};
        n_st[0].zero  = i_denom == '0;
        n_st[0].quo   = '0;
        for (int m = 1; m <= QW; m++) begin
            n_st[m] = r_st[m-1];
            n_trial = CW'(r_st[m-1].dvs) << (QW - m);
            if (r_st[m-1].rem >= n_trial) begin
                n_st[m].rem        = r_st[m-1].rem - n_trial;
                n_st[m].quo[QW-m]  = 1'b1;
            end
        end
    end

    // Apply sign and saturate; a zero amplitude sum gives zero
    always_comb begin
        if (r_st[QW].zero) begin
            n_value = '0;
        end else if (r_st[QW].neg) begin
            n_value = (r_st[QW].quo > Q_NEG) ? SAT_NEG : -$signed(r_st[QW].quo[15:0]);
        end else begin
            n_value = (r_st[QW].quo > Q_POS) ? SAT_POS : $signed(r_st[QW].quo[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m <= QW; m++) begin
                r_st[m] <= n_st[m];
            end
            r_value <= n_value;
        end
    end

    assign o_valid = r_v[QW+1];
    assign o_value = r_value;

    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_v[QW] && r_st[QW].zero) |=> (o_value == '0))
        else $error("zero amplitude sum gave a nonzero value");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_v[QW] && !r_st[QW].zero && r_st[QW].quo[QW-1]) |=>
            ((o_value == SAT_POS) || (o_value == SAT_NEG)))
        else $error("quotient overflow not saturated");

    a_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[QW] && !r_st[QW].zero && !r_st[QW].quo[QW-1]) |->
            (r_st[QW].rem < CW'(r_st[QW].dvs)))
        else $error("division remainder not below divisor");

endmodule

// ----- sv/simplex_noise_2d_fbm.sv -----
// Top level of the fractal simplex noise block: configuration registers,
// octave pipeline chain and normalizing divider. Depends on snf_pkg,
// snf_octave and snf_div.
//
// Usage:
//   Input channel i_valid/o_stall carries one point (i_x_coord, i_y_coord,
//   signed Q16.16); output channel o_valid/i_stall carries one
//   o_noise_value (signed Q1.15) per point, in order.
//   Configuration writes use i_cfg_valid/o_cfg_ready with i_cfg_index and
//   i_cfg_data; o_cfg_ready is always high and writes to unknown indexes
//   are dropped. Write configuration only while no item is in flight.
//   Throughput: one item per cycle while the output is not stalled. Every
//   item passes through every octave slot and the divider with its output
//   register, whatever the configured count.
//   Reset clears all valid bits and loads the default configuration.
//   A stall on the output while a result is valid freezes the whole pipeline
//   and raises o_stall; nothing is dropped or repeated.
module simplex_noise_2d_fbm #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_noise_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import snf_pkg::*;

    localparam logic [2:0] CFG_OCTAVES     = 3'd0;
    localparam logic [2:0] CFG_BASE_FREQ   = 3'd1;
    localparam logic [2:0] CFG_BASE_AMP    = 3'd2;
    localparam logic [2:0] CFG_LACUNARITY  = 3'd3;
    localparam logic [2:0] CFG_PERSISTENCE = 3'd4;

    logic [3:0]  r_octave_count;
    logic [15:0] r_base_frequency;
    logic [15:0] r_base_amplitude;
    logic [15:0] r_lacunarity;
    logic [15:0] r_persistence;

    logic        en;
    t_acc        w_acc [MAX_OCTAVES+1];
    logic        w_v   [MAX_OCTAVES+1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count   <= 4'd4;
            r_base_frequency <= 16'd256;
            r_base_amplitude <= 16'd256;
            r_lacunarity     <= 16'd512;
            r_persistence    <= 16'd32768;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OCTAVES:     r_octave_count   <= i_cfg_data[3:0];
                CFG_BASE_FREQ:   r_base_frequency <= i_cfg_data;
                CFG_BASE_AMP:    r_base_amplitude <= i_cfg_data;
                CFG_LACUNARITY:  r_lacunarity     <= i_cfg_data;
                CFG_PERSISTENCE: r_persistence    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Hold the whole pipeline while a result waits on a stalled receiver
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Seed the accumulator for the first octave
    always_comb begin
        w_acc[0].x     = i_x_coord;
        w_acc[0].y     = i_y_coord;
        w_acc[0].freq  = {8'h00, r_base_frequency, 8'h00};
        w_acc[0].amp   = {r_base_amplitude, 8'h00};
        w_acc[0].total = '0;
        w_acc[0].denom = '0;
        w_v[0]         = i_valid;
    end

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
        snf_octave u_octave (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (en),
            .i_valid       (w_v[k]),
            .i_active      (r_octave_count > 4'(k)),
            .i_lacunarity  (r_lacunarity),
            .i_persistence (r_persistence),
            .i_acc         (w_acc[k]),
            .o_valid       (w_v[k+1]),
            .o_acc         (w_acc[k+1])
        );
    end

    snf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_v[MAX_OCTAVES]),
        .i_total (w_acc[MAX_OCTAVES].total),
        .i_denom (w_acc[MAX_OCTAVES].denom),
        .o_valid (o_valid),
        .o_value (o_noise_value)
    );

endmodule
